>>> rtl/pdste_pkg.sv
// Shared types, codes and the control store of the PD servo torque envelope unit.
package pdste_pkg;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    // Item operations.
    localparam logic [1:0] OP_TARGET = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_DAMP   = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_TORQUE = 2'd0;
    localparam logic [1:0] ST_COMMIT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GAIN  = 3'd0;
    localparam logic [2:0] CFG_CAP   = 3'd1;
    localparam logic [2:0] CFG_STALL = 3'd2;
    localparam logic [2:0] CFG_INV   = 3'd3;
    localparam logic [2:0] CFG_LIMIT = 3'd4;

    localparam logic [15:0] GAIN_RESET  = 16'd7680;
    localparam logic [14:0] CAP_RESET   = 15'd4096;
    localparam logic [14:0] STALL_RESET = 15'd10544;
    localparam logic [15:0] INV_RESET   = 16'd992;
    localparam logic [14:0] LIMIT_RESET = 15'd2048;
    localparam logic [15:0] DAMP_RESET  = 16'd2048;

    // Datapath micro-operations.
    localparam logic [3:0] UOP_NOP     = 4'd0;
    localparam logic [3:0] UOP_STAGE   = 4'd1;
    localparam logic [3:0] UOP_IDX_CLR = 4'd2;
    localparam logic [3:0] UOP_CP_RD   = 4'd3;
    localparam logic [3:0] UOP_CP_WR   = 4'd4;
    localparam logic [3:0] UOP_RD      = 4'd5;
    localparam logic [3:0] UOP_FACTOR  = 4'd6;
    localparam logic [3:0] UOP_ENV     = 4'd7;
    localparam logic [3:0] UOP_LOAD4   = 4'd8;
    localparam logic [3:0] UOP_SUB     = 4'd9;
    localparam logic [3:0] UOP_PD      = 4'd10;
    localparam logic [3:0] UOP_DAMP_WR = 4'd11;

    // Multiplier operand pairs.
    localparam logic [1:0] MUL_SPEED = 2'd0;
    localparam logic [1:0] MUL_ENV   = 2'd1;
    localparam logic [1:0] MUL_PROP  = 2'd2;
    localparam logic [1:0] MUL_DAMP  = 2'd3;

    // Result emitted by a step.
    localparam logic [1:0] OUT_NONE   = 2'd0;
    localparam logic [1:0] OUT_TORQUE = 2'd1;
    localparam logic [1:0] OUT_COMMIT = 2'd2;
    localparam logic [1:0] OUT_REJECT = 2'd3;

    // Jump conditions.
    localparam logic [1:0] C_NONE     = 2'd0;
    localparam logic [1:0] C_NOT_LAST = 2'd1;
    localparam logic [1:0] C_NOT_OK   = 2'd2;
    localparam logic [1:0] C_MORE     = 2'd3;

    // Program entry points and jump targets.
    localparam t_pc A_TARGET = 4'd0;
    localparam t_pc A_CP_RD  = 4'd2;
    localparam t_pc A_REJ    = 4'd5;
    localparam t_pc A_HALT   = 4'd6;
    localparam t_pc A_SAMPLE = 4'd7;
    localparam t_pc A_DAMP   = 4'd15;

    typedef struct packed {
        logic [3:0] uop;
        logic [1:0] mul;
        logic       err_ld;
        logic [1:0] out;
        logic [1:0] cond;
        t_pc        jaddr;
        logic       fin;
    } t_uword;

    typedef struct packed {
        logic last;
        logic ok;
        logic more;
    } t_cond;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [14:0] torque_ceiling;
        logic [14:0] zero_speed_torque;
        logic [15:0] inv_speed;
        logic [14:0] target_limit;
    } t_cfg;

    function automatic t_uword mk(logic [3:0] uop, logic [1:0] mul, logic err_ld,
                                  logic [1:0] out, logic [1:0] cond, t_pc jaddr,
                                  logic fin);
        t_uword w;
        w.uop    = uop;
        w.mul    = mul;
        w.err_ld = err_ld;
        w.out    = out;
        w.cond   = cond;
        w.jaddr  = jaddr;
        w.fin    = fin;
        return w;
    endfunction

    // Control store: one control word per step.
    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        case (pc)
            4'd0:  w = mk(UOP_STAGE,   MUL_SPEED, 1'b0, OUT_NONE,   C_NOT_LAST, A_HALT, 1'b0);
            4'd1:  w = mk(UOP_IDX_CLR, MUL_SPEED, 1'b0, OUT_NONE,   C_NOT_OK,   A_REJ,  1'b0);
            4'd2:  w = mk(UOP_CP_RD,   MUL_SPEED, 1'b0, OUT_NONE,   C_NONE,     A_HALT, 1'b0);
            4'd3:  w = mk(UOP_CP_WR,   MUL_SPEED, 1'b0, OUT_NONE,   C_MORE,     A_CP_RD, 1'b0);
            4'd4:  w = mk(UOP_NOP,     MUL_SPEED, 1'b0, OUT_COMMIT, C_NONE,     A_HALT, 1'b1);
            4'd5:  w = mk(UOP_NOP,     MUL_SPEED, 1'b0, OUT_REJECT, C_NONE,     A_HALT, 1'b1);
            4'd6:  w = mk(UOP_NOP,     MUL_SPEED, 1'b0, OUT_NONE,   C_NONE,     A_HALT, 1'b1);
            4'd7:  w = mk(UOP_RD,      MUL_SPEED, 1'b0, OUT_NONE,   C_NONE,     A_HALT, 1'b0);
            4'd8:  w = mk(UOP_FACTOR,  MUL_SPEED, 1'b1, OUT_NONE,   C_NONE,     A_HALT, 1'b0);
            4'd9:  w = mk(UOP_NOP,     MUL_ENV,   1'b0, OUT_NONE,   C_NONE,     A_HALT, 1'b0);
            4'd10: w = mk(UOP_ENV,     MUL_PROP,  1'b0, OUT_NONE,   C_NONE,     A_HALT, 1'b0);
            4'd11: w = mk(UOP_LOAD4,   MUL_DAMP,  1'b0, OUT_NONE,   C_NONE,     A_HALT, 1'b0);
            4'd12: w = mk(UOP_SUB,     MUL_SPEED, 1'b0, OUT_NONE,   C_NONE,     A_HALT, 1'b0);
            4'd13: w = mk(UOP_PD,      MUL_SPEED, 1'b0, OUT_NONE,   C_NONE,     A_HALT, 1'b0);
            4'd14: w = mk(UOP_NOP,     MUL_SPEED, 1'b0, OUT_TORQUE, C_NONE,     A_HALT, 1'b1);
            4'd15: w = mk(UOP_DAMP_WR, MUL_SPEED, 1'b0, OUT_NONE,   C_NONE,     A_HALT, 1'b1);
            default: w = mk(UOP_NOP,   MUL_SPEED, 1'b0, OUT_NONE,   C_NONE,     A_HALT, 1'b1);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/pdste_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module pdste_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  pdste_pkg::t_pc   i_entry,
    input  pdste_pkg::t_cond i_cond,
    input  logic             i_out_free,
    output pdste_pkg::t_uword o_uw,
    output logic             o_en,
    output logic             o_busy
);
    import pdste_pkg::*;

    t_pc    r_pc, n_pc;
    logic   r_busy, n_busy;
    t_uword uw;
    logic   take;

    assign uw = ucode(r_pc);

    // A step that emits a result waits until the output register can take it.
    assign o_en   = r_busy && ((uw.out == OUT_NONE) || i_out_free);
    assign o_uw   = uw;
    assign o_busy = r_busy;

    always_comb begin
        case (uw.cond)
            C_NONE:     take = 1'b0;
            C_NOT_LAST: take = !i_cond.last;
            C_NOT_OK:   take = !i_cond.ok;
            C_MORE:     take = i_cond.more;
            default:    take = 1'b0;
        endcase
    end

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_start) begin
            n_pc   = i_entry;
            n_busy = 1'b1;
        end else if (o_en) begin
            n_pc = take ? uw.jaddr : r_pc + t_pc'(1);
            if (uw.fin) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= A_TARGET;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

endmodule

>>> rtl/pdste_dp.sv
// Datapath: joint tables, staging, shared multiplier, accumulator and result register.
module pdste_dp #(
    parameter int JOINTS = 12,
    parameter int AW     = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [3:0]        i_joint,
    input  logic signed [15:0] i_value,
    input  logic signed [15:0] i_rate,
    input  logic              i_last,
    input  pdste_pkg::t_cfg   i_cfg,
    input  pdste_pkg::t_uword i_uw,
    input  logic              i_en,
    input  logic              i_out_stall,
    output pdste_pkg::t_cond  o_cond,
    output logic              o_out_free,
    output logic              o_out_valid,
    output logic [1:0]        o_status,
    output logic [3:0]        o_joint_out,
    output logic signed [15:0] o_torque
);
    import pdste_pkg::*;

    // Captured request.
    logic [3:0]         r_joint;
    logic signed [15:0] r_value;
    logic signed [15:0] r_rate;
    logic               r_last;

    // Joint tables.
    logic [15:0]       m_tgt  [JOINTS];
    logic [15:0]       m_stg  [JOINTS];
    logic [15:0]       m_damp [JOINTS];
    logic [JOINTS-1:0] r_tgt_vld;
    logic [JOINTS-1:0] r_damp_vld;
    logic [15:0]       r_tgt_rd, r_damp_rd, r_stg_rd;
    logic              r_tgt_ok, r_damp_ok;

    // Staging control.
    logic [6:0]    r_count;
    logic          r_bad;
    logic [AW-1:0] r_idx;

    // Arithmetic registers.
    logic signed [16:0] r_err;
    logic signed [41:0] r_prod;
    logic [22:0]        r_fac;
    logic [14:0]        r_avail;
    logic signed [35:0] r_acc;
    logic signed [25:0] r_pd;

    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [3:0]         r_joint_out;
    logic signed [15:0] r_torque;

    logic [AW+3:0]      joint_wide;
    logic [AW-1:0]      jaddr;
    logic [AW-1:0]      saddr;
    logic [15:0]        tgt_val, damp_val;
    logic [16:0]        value_x, rate_x, value_mag, rate_mag;
    logic signed [17:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [41:0] mul_p;
    logic [14:0]        env;
    logic signed [35:0] acc_rnd;
    logic signed [25:0] avail_s;
    logic signed [15:0] torque_c;
    logic               stage_wr;

    assign joint_wide = (AW + 4)'(r_joint);
    assign jaddr      = joint_wide[AW-1:0];
    assign saddr      = r_count[AW-1:0];
    assign stage_wr   = i_en && (i_uw.uop == UOP_STAGE) && (r_count < 7'(JOINTS));

    // Entries never written read as their reset values.
    assign tgt_val  = r_tgt_ok ? r_tgt_rd : 16'd0;
    assign damp_val = r_damp_ok ? r_damp_rd : DAMP_RESET;

    assign value_x   = {r_value[15], r_value};
    assign rate_x    = {r_rate[15], r_rate};
    assign value_mag = r_value[15] ? 17'd0 - value_x : value_x;
    assign rate_mag  = r_rate[15] ? 17'd0 - rate_x : rate_x;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_joint <= i_joint;
            r_value <= i_value;
            r_rate  <= i_rate;
            r_last  <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && (i_uw.uop == UOP_CP_WR)) begin
            m_tgt[r_idx] <= r_stg_rd;
        end
        if (i_en && (i_uw.uop == UOP_RD)) begin
            r_tgt_rd <= m_tgt[jaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_wr) begin
            m_stg[saddr] <= r_value;
        end
        if (i_en && (i_uw.uop == UOP_CP_RD)) begin
            r_stg_rd <= m_stg[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && (i_uw.uop == UOP_DAMP_WR)) begin
            m_damp[jaddr] <= r_value;
        end
        if (i_en && (i_uw.uop == UOP_RD)) begin
            r_damp_rd <= m_damp[jaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_vld  <= '0;
            r_damp_vld <= '0;
        end else begin
            if (i_en && (i_uw.uop == UOP_CP_WR)) begin
                r_tgt_vld[r_idx] <= 1'b1;
            end
            if (i_en && (i_uw.uop == UOP_DAMP_WR)) begin
                r_damp_vld[jaddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && (i_uw.uop == UOP_RD)) begin
            r_tgt_ok  <= r_tgt_vld[jaddr];
            r_damp_ok <= r_damp_vld[jaddr];
        end
    end

    // Staging count, bad flag and copy index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bad   <= 1'b0;
            r_idx   <= '0;
        end else if (i_en) begin
            if (i_uw.uop == UOP_STAGE) begin
                if ((value_mag > {2'b00, i_cfg.target_limit}) || (r_count >= 7'(JOINTS))) begin
                    r_bad <= 1'b1;
                end
                if (r_count != 7'd127) begin
                    r_count <= r_count + 7'd1;
                end
            end
            if (i_uw.uop == UOP_IDX_CLR) begin
                r_idx <= '0;
            end
            if (i_uw.uop == UOP_CP_WR) begin
                r_idx <= r_idx + AW'(1);
            end
            if ((i_uw.out == OUT_COMMIT) || (i_uw.out == OUT_REJECT)) begin
                r_count <= '0;
                r_bad   <= 1'b0;
            end
        end
    end

    assign o_cond.last = r_last;
    assign o_cond.ok   = !r_bad && (r_count == 7'(JOINTS));
    assign o_cond.more = r_idx != AW'(JOINTS - 1);

    // Shared multiplier, one operand pair per step.
    always_comb begin
        case (i_uw.mul)
            MUL_SPEED: begin
                mul_a = $signed({1'b0, rate_mag});
                mul_b = $signed({8'd0, i_cfg.inv_speed});
            end
            MUL_ENV: begin
                mul_a = $signed({3'd0, i_cfg.zero_speed_torque});
                mul_b = $signed({1'b0, r_fac});
            end
            MUL_PROP: begin
                mul_a = $signed({2'd0, i_cfg.prop_gain});
                mul_b = $signed({{7{r_err[16]}}, r_err});
            end
            MUL_DAMP: begin
                mul_a = $signed({{2{damp_val[15]}}, damp_val});
                mul_b = $signed({{8{r_rate[15]}}, r_rate});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign env     = r_prod[36:22];
    assign acc_rnd = r_acc + 36'sd512;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= mul_p;
            if (i_uw.err_ld) begin
                r_err <= $signed({tgt_val[15], tgt_val}) - $signed(value_x);
            end
            case (i_uw.uop)
                UOP_FACTOR: begin
                    // The product is |dq|*inv_speed; the factor floors at zero.
                    r_fac <= (r_prod[41:22] != 20'd0) ? 23'd0 : 23'h400000 - r_prod[22:0];
                end
                UOP_ENV: begin
                    r_avail <= (env < i_cfg.torque_ceiling) ? env : i_cfg.torque_ceiling;
                end
                UOP_LOAD4: begin
                    r_acc <= $signed({r_prod[33:0], 2'b00});
                end
                UOP_SUB: begin
                    r_acc <= r_acc - r_prod[35:0];
                end
                UOP_PD: begin
                    r_pd <= acc_rnd[35:10];
                end
                default: begin
                end
            endcase
        end
    end

    assign avail_s = $signed({11'd0, r_avail});

    always_comb begin
        if (r_pd > avail_s) begin
            torque_c = $signed({1'b0, r_avail});
        end else if (r_pd < -avail_s) begin
            torque_c = -$signed({1'b0, r_avail});
        end else begin
            torque_c = r_pd[15:0];
        end
    end

    assign o_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en && (i_uw.out != OUT_NONE)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (i_uw.out)
                OUT_TORQUE: begin
                    r_status    <= ST_TORQUE;
                    r_joint_out <= r_joint;
                    r_torque    <= torque_c;
                end
                OUT_COMMIT: begin
                    r_status    <= ST_COMMIT;
                    r_joint_out <= 4'd0;
                    r_torque    <= 16'sd0;
                end
                OUT_REJECT: begin
                    r_status    <= ST_REJECT;
                    r_joint_out <= 4'd0;
                    r_torque    <= 16'sd0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_joint_out = r_joint_out;
    assign o_torque    = r_torque;

endmodule

>>> rtl/pd_servo_torque_envelope_unit.sv
// Top level of the PD servo torque envelope unit: configuration, dispatch and control.
//
// Each request runs a short microprogram on one shared 18x24 multiplier, one step per
// cycle, and the input stalls until the program ends. A control sample forms the speed
// factor, the envelope and the PD sum, and its last step writes the torque to the output
// register. A damping load writes its table entry, and a target element without the last
// flag stages its value. The element that closes a batch runs the copy loop, which moves
// one staged target at a time through the staging table's registered read port, when the
// batch commits and skips it when the batch is rejected; its status is written to the
// output register by the program's last step. The next request is accepted as soon as the
// program ends, while the result may still wait in the output register; a step that emits
// a result waits for as long as that register is full and stalled. Samples and damping
// loads for a joint at or beyond JOINTS, and requests for an unused op, give no result.
module pd_servo_torque_envelope_unit #(
    parameter int JOINTS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic [3:0]        i_joint,
    input  logic signed [15:0] i_value,
    input  logic signed [15:0] i_rate,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [3:0]        o_joint_out,
    output logic signed [15:0] o_torque,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import pdste_pkg::*;

    localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    t_cfg    r_cfg;
    t_uword  uw;
    t_cond   cond;
    t_pc     entry;
    logic    busy, en, out_free;
    logic    accept, start, runs, in_range;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = busy;
    assign accept      = i_in_valid && !busy;
    assign in_range    = {3'd0, i_joint} < 7'(JOINTS);
    assign start       = accept && runs;

    always_comb begin
        case (i_op)
            OP_TARGET: begin
                entry = A_TARGET;
                runs  = 1'b1;
            end
            OP_SAMPLE: begin
                entry = A_SAMPLE;
                runs  = in_range;
            end
            OP_DAMP: begin
                entry = A_DAMP;
                runs  = in_range;
            end
            default: begin
                entry = A_HALT;
                runs  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain         <= GAIN_RESET;
            r_cfg.torque_ceiling    <= CAP_RESET;
            r_cfg.zero_speed_torque <= STALL_RESET;
            r_cfg.inv_speed         <= INV_RESET;
            r_cfg.target_limit      <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GAIN:  r_cfg.prop_gain         <= i_cfg_data;
                CFG_CAP:   r_cfg.torque_ceiling    <= i_cfg_data[14:0];
                CFG_STALL: r_cfg.zero_speed_torque <= i_cfg_data[14:0];
                CFG_INV:   r_cfg.inv_speed         <= i_cfg_data;
                CFG_LIMIT: r_cfg.target_limit      <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    pdste_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_entry    (entry),
        .i_cond     (cond),
        .i_out_free (out_free),
        .o_uw       (uw),
        .o_en       (en),
        .o_busy     (busy)
    );

    pdste_dp #(
        .JOINTS (JOINTS),
        .AW     (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_joint     (i_joint),
        .i_value     (i_value),
        .i_rate      (i_rate),
        .i_last      (i_last),
        .i_cfg       (r_cfg),
        .i_uw        (uw),
        .i_en        (en),
        .i_out_stall (i_out_stall),
        .o_cond      (cond),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_joint_out (o_joint_out),
        .o_torque    (o_torque)
    );

    // The sequencer only starts on an accepted request.
    a_busy_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(accept))
        else $error("sequencer started without an accepted request");

    // An unused op is dropped at once and leaves the block free.
    a_unused_op_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_SPARE)) |=> !o_in_stall)
        else $error("unused op occupied the sequencer");

    // Batch status results carry zero joint and torque.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_TORQUE))
            |-> ((o_torque == 16'sd0) && (o_joint_out == 4'd0)))
        else $error("batch status result carries joint or torque");

endmodule

>>> tb/sv/pdste_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the results of the PD servo torque envelope unit.
package pdste_scoreboard_pkg;
    import pdste_pkg::*;

    localparam int JOINTS = 12;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         status;
        logic [3:0]         joint;
        logic signed [15:0] torque;
    } t_servo_result;

    class servo_scoreboard;
        logic [15:0]        gain;
        logic [14:0]        cap;
        logic [14:0]        stall;
        logic [15:0]        inv_speed;
        logic [14:0]        limit;
        logic signed [15:0] target_tab [JOINTS];
        logic signed [15:0] staged_tab [JOINTS];
        logic signed [15:0] damp_tab   [JOINTS];
        int unsigned        staged_cnt;
        bit                 staged_bad;
        t_servo_result      awaited [$];
        int unsigned        mismatches;
        int unsigned        n_torque;
        int unsigned        n_commit;
        int unsigned        n_reject;

        function new();
            gain       = GAIN_RESET;
            cap        = CAP_RESET;
            stall      = STALL_RESET;
            inv_speed  = INV_RESET;
            limit      = LIMIT_RESET;
            for (int i = 0; i < JOINTS; i++) begin
                target_tab[i] = '0;
                staged_tab[i] = '0;
                damp_tab[i]   = DAMP_RESET;
            end
            staged_cnt = 0;
            staged_bad = 1'b0;
            mismatches = 0;
            n_torque   = 0;
            n_commit   = 0;
            n_reject   = 0;
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [15:0] data);
            case (idx)
                CFG_GAIN:  gain      = data;
                CFG_CAP:   cap       = data[14:0];
                CFG_STALL: stall     = data[14:0];
                CFG_INV:   inv_speed = data;
                CFG_LIMIT: limit     = data[14:0];
                default: ;
            endcase
        endfunction

        // PD term rounded to Q3.12, then clamped to the speed-dependent envelope.
        function logic signed [15:0] torque_for(input int j, input logic signed [15:0] q,
                                                input logic signed [15:0] dq);
            longint err, prop, damp, sum, pd, speed, factor, env, avail, t;
            err    = longint'(target_tab[j]) - longint'(q);
            prop   = longint'(gain) * err;
            damp   = longint'(damp_tab[j]) * longint'(dq);
            sum    = 4 * prop - damp;
            pd     = (sum + 512) >>> 10;
            speed  = (dq < 0) ? -longint'(dq) : longint'(dq);
            factor = (longint'(1) << 22) - speed * longint'(inv_speed);
            if (factor < 0) factor = 0;
            env    = (longint'(stall) * factor) >>> 22;
            avail  = (env < longint'(cap)) ? env : longint'(cap);
            t      = pd;
            if (t > avail) t = avail;
            if (t < -avail) t = -avail;
            return t[15:0];
        endfunction

        function void note_request(input logic [1:0] op, input logic [3:0] joint,
                                   input logic signed [15:0] value,
                                   input logic signed [15:0] rate, input logic last);
            int            v;
            int            mag;
            bit            ok;
            t_servo_result r;
            v = value;
            if (op == OP_TARGET) begin
                mag = (v < 0) ? -v : v;
                if (mag > int'(limit)) staged_bad = 1'b1;
                if (staged_cnt < JOINTS) staged_tab[staged_cnt] = value;
                else staged_bad = 1'b1;
                if (staged_cnt < 127) staged_cnt++;
                if (last) begin
                    ok = !staged_bad && staged_cnt == JOINTS;
                    if (ok) begin
                        for (int i = 0; i < JOINTS; i++) target_tab[i] = staged_tab[i];
                    end
                    staged_cnt = 0;
                    staged_bad = 1'b0;
                    r.status = ok ? ST_COMMIT : ST_REJECT;
                    r.joint  = '0;
                    r.torque = '0;
                    awaited.insert(awaited.size(), r);
                end
            end else if (op == OP_DAMP) begin
                if (joint < JOINTS) damp_tab[joint] = value;
            end else if (op == OP_SAMPLE && joint < JOINTS) begin
                r.status = ST_TORQUE;
                r.joint  = joint;
                r.torque = torque_for(int'(joint), value, rate);
                awaited.insert(awaited.size(), r);
            end
        endfunction

        task report(input string msg);
            mismatches++;
            $display("MISMATCH %0d: %s", mismatches, msg);
        endtask

        task check_result(input logic [1:0] status, input logic [3:0] joint,
                          input logic signed [15:0] torque);
            t_servo_result want;
            if (awaited.size() == 0) begin
                report($sformatf("result with nothing outstanding: status %0d joint %0d torque %0d",
                                 status, joint, torque));
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status)
                report($sformatf("status %0d, expected %0d", status, want.status));
            if (joint !== want.joint)
                report($sformatf("joint %0d, expected %0d", joint, want.joint));
            if (torque !== want.torque)
                report($sformatf("joint %0d torque %0d, expected %0d",
                                 want.joint, torque, want.torque));
            case (want.status)
                ST_TORQUE: n_torque++;
                ST_COMMIT: n_commit++;
                default:   n_reject++;
            endcase
        endtask
    endclass

endpackage

>>> tb/sv/tb_pd_servo_torque_envelope_unit.sv
// Top-level testbench of the PD servo torque envelope unit: stimulus, flow control and checks.
module tb_pd_servo_torque_envelope_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pdste_pkg::*;
    import pdste_scoreboard_pkg::*;

    localparam int SETTLE_CYCLES  = 2 * JOINTS + 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_op;
    logic [3:0]         i_joint;
    logic signed [15:0] i_value;
    logic signed [15:0] i_rate;
    logic               i_last;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic [3:0]         o_joint_out;
    logic signed [15:0] o_torque;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    servo_scoreboard sb;
    bit              tx_idles;
    bit              rx_idles;
    bit              hold_off_req;
    int unsigned     sent;
    int unsigned     settings_done;

    pd_servo_torque_envelope_unit #(
        .JOINTS(JOINTS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_joint     (i_joint),
        .i_value     (i_value),
        .i_rate      (i_rate),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_joint_out (o_joint_out),
        .o_torque    (o_torque),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or one long hold-off on request from the main flow.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall  = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_stall = rx_idles && ($urandom_range(99) < 13);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_result(o_status, o_joint_out, o_torque);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0)
                    || (o_out_valid === 1'b1 && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_req(input logic [1:0] op, input logic [3:0] joint,
                            input logic signed [15:0] value, input logic signed [15:0] rate,
                            input logic last);
        while (tx_idles && $urandom_range(99) < 13) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_op       = op;
        i_joint    = joint;
        i_value    = value;
        i_rate     = rate;
        i_last     = last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(op, joint, value, rate, last);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic write_settings(input logic [15:0] g, input logic [15:0] c,
                                  input logic [15:0] s, input logic [15:0] v,
                                  input logic [15:0] l);
        logic [2:0]  idx  [5];
        logic [15:0] vals [5];
        idx  = '{CFG_GAIN, CFG_CAP, CFG_STALL, CFG_INV, CFG_LIMIT};
        vals = '{g, c, s, v, l};
        for (int k = 0; k < 5; k++) begin
            i_cfg_valid = 1'b1;
            i_cfg_index = idx[k];
            i_cfg_data  = vals[k];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            sb.write_reg(idx[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
        settings_done++;
    endtask

    // Stop offering, wait for every outstanding result, then let a closing batch finish.
    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_target();
        int m;
        m = ($urandom_range(9) == 0) ? int'(sb.limit) : int'($urandom_range(sb.limit, 0));
        return 16'($urandom_range(1) ? -m : m);
    endfunction

    function automatic logic signed [15:0] pick_bad();
        int m;
        if (sb.limit == 15'h7FFF || $urandom_range(3) == 0) return 16'sh8000;
        m = int'($urandom_range(32767, int'(sb.limit) + 1));
        return 16'($urandom_range(1) ? -m : m);
    endfunction

    function automatic logic signed [15:0] pick_rate();
        int r;
        case ($urandom_range(3))
            0:       r = int'($urandom_range(32)) - 16;
            1:       r = int'($urandom_range(2046)) - 1023;
            2:       r = int'($urandom_range(16382)) - 8191;
            default: r = int'($urandom);
        endcase
        return 16'(r);
    endfunction

    // Positions mostly near the joint's target so the PD term is not always saturated.
    function automatic logic signed [15:0] pick_pos(input int j);
        int p;
        if ($urandom_range(4) == 0) return 16'($urandom);
        p = int'(sb.target_tab[j]) + int'($urandom_range(600)) - 300;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return 16'(p);
    endfunction

    task automatic send_batch(input int len, input int bad_at);
        logic signed [15:0] v;
        for (int k = 0; k < len; k++) begin
            v = (k == bad_at) ? pick_bad() : pick_target();
            send_req(OP_TARGET, 4'($urandom_range(15)), v, 16'($urandom), k == len - 1);
        end
    endtask

    task automatic send_sample(input int j);
        send_req(OP_SAMPLE, 4'(j), pick_pos(j), pick_rate(), 1'($urandom_range(1)));
    endtask

    task automatic run_directed();
        int lim;
        lim = int'(sb.limit);
        // Zero error, full error, and the speed envelope closed at both rate extremes.
        send_req(OP_SAMPLE, 4'd0, 16'sd0, 16'sd0, 1'b0);
        send_req(OP_SAMPLE, 4'd11, 16'sh8000, 16'sd0, 1'b1);
        send_req(OP_SAMPLE, 4'd5, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_req(OP_SAMPLE, 4'd3, 16'sd0, 16'sh8000, 1'b0);
        // Negative damping is taken as it comes.
        send_req(OP_DAMP, 4'd0, 16'sh8000, 16'sd0, 1'b0);
        send_req(OP_DAMP, 4'd11, 16'sh7FFF, 16'shFFFF, 1'b1);
        // Joints past the table and the unused op must not answer.
        send_req(OP_DAMP, 4'd12, 16'sd100, 16'sd0, 1'b0);
        send_req(OP_SAMPLE, 4'd15, 16'shFFFF, 16'shFFFF, 1'b1);
        send_req(OP_UNUSED, 4'd7, 16'sh5A5A, 16'shA5A5, 1'b1);
        send_req(OP_SAMPLE, 4'd0, 16'sd100, 16'sd200, 1'b0);
        send_req(OP_SAMPLE, 4'd11, -16'sd100, -16'sd300, 1'b0);
        // Full batch sitting exactly on the limit, then a lone most-negative target.
        for (int k = 0; k < JOINTS; k++)
            send_req(OP_TARGET, 4'($urandom_range(15)), 16'(k[0] ? -lim : lim),
                     16'($urandom), k == JOINTS - 1);
        send_req(OP_TARGET, 4'd0, 16'sh8000, 16'sd0, 1'b1);
        send_req(OP_SAMPLE, 4'd11, 16'sd0, 16'sd40, 1'b0);
    endtask

    task automatic run_random(input int n);
        int unsigned stop_at;
        int          shape;
        int          len;
        stop_at = sent + n;
        while (sent < stop_at) begin
            shape = $urandom_range(99);
            if (shape < 28) begin
                send_batch(JOINTS, -1);
            end else if (shape < 58) begin
                len = $urandom_range(6, 1);
                repeat (len) send_sample($urandom_range(JOINTS - 1));
            end else if (shape < 68) begin
                len = $urandom_range(3, 1);
                repeat (len)
                    send_req(OP_DAMP, 4'($urandom_range(JOINTS - 1)),
                             ($urandom_range(3) == 0) ? 16'($urandom)
                                                      : 16'(int'($urandom_range(8192)) - 4096),
                             16'($urandom), 1'($urandom_range(1)));
            end else if (shape < 76) begin
                send_batch(JOINTS, $urandom_range(JOINTS - 1));
            end else if (shape < 82) begin
                send_batch($urandom_range(JOINTS - 1, 1), -1);
            end else if (shape < 87) begin
                send_batch($urandom_range(JOINTS + 8, JOINTS + 1), -1);
            end else if (shape < 94) begin
                case ($urandom_range(2))
                    0: send_req(OP_UNUSED, 4'($urandom), 16'($urandom), 16'($urandom),
                                1'($urandom));
                    1: send_req(OP_SAMPLE, 4'($urandom_range(15, JOINTS)), 16'($urandom),
                                16'($urandom), 1'($urandom));
                    default: send_req(OP_DAMP, 4'($urandom_range(15, JOINTS)), 16'($urandom),
                                      16'($urandom), 1'($urandom));
                endcase
            end else begin
                send_req(OP_TARGET, 4'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        logic [15:0] g, c, s, v, l;
        sb            = new();
        tx_idles      = 1'b1;
        rx_idles      = 1'b1;
        hold_off_req  = 1'b0;
        sent          = 0;
        settings_done = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = OP_TARGET;
        i_joint       = '0;
        i_value       = '0;
        i_rate        = '0;
        i_last        = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_GAIN;
        i_cfg_data    = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_random(150);
        drain();

        write_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(60);
        drain();

        // Everything at its top value, with neither side idling.
        tx_idles = 1'b0;
        rx_idles = 1'b0;
        write_settings(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF);
        run_random(150);
        drain();
        tx_idles = 1'b1;
        rx_idles = 1'b1;

        // Open envelope so the PD term shows through; the receiver holds off meanwhile.
        write_settings(16'd256, 16'h7FFF, 16'h7FFF, 16'd0, 16'd16384);
        hold_off_req = 1'b1;
        run_random(200);
        drain();

        for (int p = 0; p < 4; p++) begin
            g = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1023));
            c = 16'($urandom_range(32767));
            s = 16'($urandom_range(32767));
            v = $urandom_range(1) ? 16'($urandom_range(2047)) : 16'($urandom);
            l = 16'($urandom_range(32767));
            write_settings(g, c, s, v, l);
            // Long enough to drive the staged count into saturation.
            if (p == 0) send_batch(130, -1);
            run_random(100);
            drain();
        end

        $display("Sent %0d requests over %0d register settings, with a %0d-cycle output hold-off.",
                 sent, settings_done, HOLD_CYCLES);
        $display("Checked %0d torque results, %0d committed and %0d rejected target batches.",
                 sb.n_torque, sb.n_commit, sb.n_reject);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
